// ----- sv/id3_pkg.sv -----
// ----------------------------------------------------------------------------
// id3_pkg
// Shared types, register indexes and frame id constants of the ID3v2.3
// frame rewriter.
// ----------------------------------------------------------------------------
package id3_pkg;

  // size of the replacement text store
  localparam int MAX_TEXT_DEF = 63;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 6;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_SELECT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_LENGTH  = 1'd1;

  // request operations
  localparam logic OP_LOAD_TEXT = 1'b0;
  localparam logic OP_SOURCE    = 1'b1;

  // supported frame ids, in selector order
  localparam logic [2:0] NUM_FRAME_IDS = 3'd6;
  localparam logic [31:0] ID_TIT2 = "TIT2";
  localparam logic [31:0] ID_TPE1 = "TPE1";
  localparam logic [31:0] ID_TALB = "TALB";
  localparam logic [31:0] ID_TYER = "TYER";
  localparam logic [31:0] ID_TCON = "TCON";
  localparam logic [31:0] ID_COMM = "COMM";

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_text;   // accepted request writes the text store
    logic src_step;    // accepted request is a source byte
    logic word_emit;   // move the next byte of the emit word to the output
    logic text_run;    // stream the replacement text to the output
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic src_has_out; // the presented source byte causes results
    logic word_last;   // one byte left in the emit word
    logic text_pend;   // replacement text follows the emit word
    logic out_free;    // output register can take a byte
    logic text_done;   // last text byte moves to the output now
  } dp_status_t;

  // one byte of a frame id, msb first
  function automatic logic [7:0] frame_id_byte(logic [2:0] sel, logic [1:0] pos);
    logic [31:0] id;
    case (sel)
      3'd0:    id = ID_TIT2;
      3'd1:    id = ID_TPE1;
      3'd2:    id = ID_TALB;
      3'd3:    id = ID_TYER;
      3'd4:    id = ID_TCON;
      3'd5:    id = ID_COMM;
      default: id = '0;
    endcase
    case (pos)
      2'd0:    frame_id_byte = id[31:24];
      2'd1:    frame_id_byte = id[23:16];
      2'd2:    frame_id_byte = id[15:8];
      default: frame_id_byte = id[7:0];
    endcase
  endfunction

endpackage

// ----- sv/id3v2_frame_rewriter.sv -----
// ----------------------------------------------------------------------------
// id3v2_frame_rewriter
// Rewrites one selected ID3v2.3 frame in a byte stream: new size, encoding
// byte and stored replacement text; all other bytes pass unchanged.
// ----------------------------------------------------------------------------
// Results: the emit word of a source byte is registered when the request is
//   accepted, and its bytes then enter the output register as it frees; text
//   loads give no result. A new request is taken only after the last result
//   of the previous one; the replacement text streams one byte per cycle while
//   the output register is free, after the first text store read.
// Reset: synchronous, clears parser, shifter and text stream state and output
//   valid, sets the configuration defaults; text store keeps its contents.
module id3v2_frame_rewriter #(
  parameter int MAX_TEXT = id3_pkg::MAX_TEXT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [id3_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [id3_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           op,
  input  logic [7:0]                     data_byte,
  input  logic [5:0]                     text_index,
  input  logic                           end_of_file,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic                           run_last
);
  import id3_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // controller
  id3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  // datapath
  id3_dp #(
    .MAX_TEXT (MAX_TEXT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .data_byte   (data_byte),
    .text_index  (text_index),
    .end_of_file (end_of_file),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .run_last    (run_last)
  );

endmodule

// ----- sv/id3_ram.sv -----
// ----------------------------------------------------------------------------
// id3_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module id3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/id3_ctrl.sv -----
// ----------------------------------------------------------------------------
// id3_ctrl
// Controller: accepts requests and sequences the result bursts of the
// datapath (emit word bytes, then optional replacement text).
// ----------------------------------------------------------------------------
module id3_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               op,
  output logic               in_ready,
  output id3_pkg::dp_cmd_t   cmd,
  input  id3_pkg::dp_status_t status
);
  import id3_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WORD = 2'd1;
  localparam logic [1:0] S_TEXT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (op == OP_LOAD_TEXT) begin
            cmd.load_text = 1'b1;
          end else begin
            cmd.src_step = 1'b1;
            if (status.src_has_out) begin
              state_next = S_WORD;
            end
          end
        end
      end
      S_WORD: begin
        if (status.out_free) begin
          cmd.word_emit = 1'b1;
          if (status.word_last) begin
            state_next = status.text_pend ? S_TEXT : S_IDLE;
          end
        end
      end
      S_TEXT: begin
        cmd.text_run = 1'b1;
        if (status.text_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/id3_dp.sv -----
// ----------------------------------------------------------------------------
// id3_dp
// Datapath: configuration registers, tag and frame parser state, emit word
// shifter, replacement text store with its read pointer, output register.
// ----------------------------------------------------------------------------
module id3_dp #(
  parameter int MAX_TEXT = id3_pkg::MAX_TEXT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [id3_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [id3_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [7:0]                     data_byte,
  input  logic [5:0]                     text_index,
  input  logic                           end_of_file,
  input  id3_pkg::dp_cmd_t               cmd,
  output id3_pkg::dp_status_t            status,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic                           run_last
);
  import id3_pkg::*;

  localparam int AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam logic [5:0] MAX_TEXT_V = 6'(MAX_TEXT);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_ID      = 3'd1;
  localparam logic [2:0] PH_SIZE    = 3'd2;
  localparam logic [2:0] PH_FLAGS   = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_COPY    = 3'd5;

  // configuration
  logic [2:0]  frame_select;
  logic [5:0]  text_length;
  logic [5:0]  tl;

  // parser state
  logic [2:0]  phase;
  logic [31:0] offset;
  logic [28:0] tag_end;
  logic [28:0] fcount;
  logic [31:0] size_buf;
  logic        id_match;

  logic [2:0]  phase_next;
  logic [31:0] offset_next;
  logic [28:0] tag_end_next;
  logic [28:0] fcount_next;
  logic [31:0] size_buf_next;
  logic        id_match_next;

  // burst to emit for the presented byte
  logic [31:0] emit_word;
  logic [2:0]  emit_cnt;
  logic        emit_text;

  // emit word shifter
  logic [31:0] word;
  logic [2:0]  wcnt;
  logic        text_pend;

  // text streaming
  logic [5:0]  rd_ptr;
  logic [5:0]  left;
  logic        dvalid;
  logic        rd_en;
  logic        take;
  logic [7:0]  rd_data;
  logic        ram_we;

  // helper terms
  logic [28:0] fcount_inc;
  logic [31:0] size_shift;
  logic [31:0] hdr_acc;
  logic        off_past;
  logic        sel_ok;
  logic        out_free;

  assign tl = (text_length > MAX_TEXT_V) ? MAX_TEXT_V : text_length;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_select <= 3'd0;
      text_length  <= 6'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAME_SELECT: frame_select <= cfg_data[2:0];
        CFG_TEXT_LENGTH:  text_length  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign fcount_inc = fcount + 29'd1;
  assign size_shift = {size_buf[23:0], data_byte};
  assign hdr_acc    = ((offset == 32'd6) ? 32'd0 : (size_buf << 7)) |
                      {25'd0, data_byte[6:0]};
  assign off_past   = (offset >= {3'd0, tag_end});
  assign sel_ok     = (frame_select < NUM_FRAME_IDS);

  // parser step for one source byte
  always_comb begin
    phase_next    = phase;
    offset_next   = offset + 32'd1;
    tag_end_next  = tag_end;
    fcount_next   = fcount;
    size_buf_next = size_buf;
    id_match_next = id_match;
    emit_word     = {data_byte, 24'd0};
    emit_cnt      = 3'd1;
    emit_text     = 1'b0;
    case (phase)
      PH_HEADER: begin
        if (offset >= 32'd6 && offset <= 32'd9) begin
          size_buf_next = hdr_acc;
        end
        if (offset == 32'd9) begin
          tag_end_next = {1'b0, hdr_acc[27:0]} + 29'd10;
          phase_next   = PH_ID;
          fcount_next  = '0;
        end
      end
      PH_ID: begin
        if (fcount == '0 && (off_past || data_byte == 8'h00)) begin
          // tag end or zero padding: copy the rest
          phase_next = PH_COPY;
        end else begin
          id_match_next = (fcount == '0 || id_match) && sel_ok &&
                          (frame_id_byte(frame_select, fcount[1:0]) == data_byte);
          fcount_next   = fcount_inc;
          if (fcount_inc == 29'd4) begin
            phase_next    = PH_SIZE;
            fcount_next   = '0;
            size_buf_next = '0;
          end
        end
      end
      PH_SIZE: begin
        size_buf_next = size_shift;
        fcount_next   = fcount_inc;
        emit_cnt      = 3'd0;
        if (fcount_inc == 29'd4) begin
          fcount_next = '0;
          emit_cnt    = 3'd4;
          if (size_shift == 32'd0 || size_shift > {3'd0, tag_end}) begin
            // bad frame size: pass it and copy the rest
            phase_next = PH_COPY;
            emit_word  = size_shift;
          end else begin
            phase_next = PH_FLAGS;
            emit_word  = id_match ? {24'd0, 8'({2'd0, tl}) + 8'd1} : size_shift;
          end
        end
      end
      PH_FLAGS: begin
        fcount_next = fcount_inc;
        if (fcount_inc == 29'd2) begin
          phase_next  = PH_PAYLOAD;
          fcount_next = '0;
        end
      end
      PH_PAYLOAD: begin
        if (id_match) begin
          if (fcount == '0) begin
            // encoding byte, then the stored text
            emit_word = 32'd0;
            emit_text = (tl != 6'd0);
          end else begin
            emit_cnt = 3'd0;
          end
        end
        fcount_next = fcount_inc;
        if ({3'd0, fcount_inc} >= size_buf) begin
          phase_next  = PH_ID;
          fcount_next = '0;
        end
      end
      default: begin
      end
    endcase

    // end of file: release held size bytes, then restart parsing
    if (end_of_file) begin
      if (phase_next == PH_SIZE && fcount_next != '0) begin
        emit_cnt = fcount_next[2:0];
        case (fcount_next[1:0])
          2'd1:    emit_word = {size_buf_next[7:0], 24'd0};
          2'd2:    emit_word = {size_buf_next[15:0], 16'd0};
          default: emit_word = {size_buf_next[23:0], 8'd0};
        endcase
      end
      phase_next    = PH_HEADER;
      offset_next   = '0;
      tag_end_next  = '0;
      fcount_next   = '0;
      size_buf_next = '0;
      id_match_next = 1'b0;
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      offset   <= '0;
      tag_end  <= '0;
      fcount   <= '0;
      size_buf <= '0;
      id_match <= 1'b0;
    end else if (cmd.src_step) begin
      phase    <= phase_next;
      offset   <= offset_next;
      tag_end  <= tag_end_next;
      fcount   <= fcount_next;
      size_buf <= size_buf_next;
      id_match <= id_match_next;
    end
  end

  // emit word shifter
  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt      <= 3'd0;
      text_pend <= 1'b0;
    end else if (cmd.src_step) begin
      wcnt      <= emit_cnt;
      text_pend <= emit_text;
    end else if (cmd.word_emit) begin
      wcnt <= wcnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.src_step) begin
      word <= emit_word;
    end else if (cmd.word_emit) begin
      word <= {word[23:0], 8'd0};
    end
  end

  // text store
  assign ram_we = cmd.load_text && (text_index < MAX_TEXT_V);

  id3_ram #(
    .WIDTH (8),
    .DEPTH (MAX_TEXT)
  ) u_text_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (text_index[AW-1:0]),
    .wdata (data_byte),
    .re    (rd_en),
    .raddr (rd_ptr[AW-1:0]),
    .rdata (rd_data)
  );

  // text streaming: while text runs and text is left, a read is issued whenever the read register is free
  assign out_free = !out_valid || out_ready;
  assign take     = cmd.text_run && dvalid && out_free;
  assign rd_en    = cmd.text_run && (!dvalid || take) && (rd_ptr < tl);

  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid <= 1'b0;
      rd_ptr <= '0;
      left   <= '0;
    end else if (cmd.src_step) begin
      dvalid <= 1'b0;
      rd_ptr <= '0;
      left   <= tl;
    end else begin
      if (rd_en) begin
        dvalid <= 1'b1;
        rd_ptr <= rd_ptr + 6'd1;
      end else if (take) begin
        dvalid <= 1'b0;
      end
      if (take) begin
        left <= left - 6'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.word_emit || take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.word_emit) begin
      out_byte <= word[31:24];
      run_last <= (wcnt == 3'd1) && !text_pend;
    end else if (take) begin
      out_byte <= rd_data;
      run_last <= (left == 6'd1);
    end
  end

  // status to the controller
  always_comb begin
    status             = '0;
    status.src_has_out = (emit_cnt != 3'd0);
    status.word_last   = (wcnt == 3'd1);
    status.text_pend   = text_pend;
    status.out_free    = out_free;
    status.text_done   = take && (left == 6'd1);
  end

endmodule

// ----- sv/id3_checker.sv -----
// ----------------------------------------------------------------------------
// id3_checker
// Port level checks of the frame rewriter, bound to the top level.
// ----------------------------------------------------------------------------
module id3_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       op,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last
);
  import id3_pkg::*;

  // stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
    else $error("stalled result changed");

  // a new request is taken only after the last byte of the previous run
  a_run_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_last |-> !in_ready)
    else $error("request taken in the middle of a run");

  // a text load produces no result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (op == OP_LOAD_TEXT) && !out_valid |=> !out_valid)
    else $error("text load produced a result");

  // after a run ends with the block idle and no request, no stray result appears
  a_no_stray: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && run_last && in_ready && !in_valid |=> !out_valid)
    else $error("result appeared without a request");

endmodule

bind id3v2_frame_rewriter id3_checker u_id3_checker (.*);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ID3v2.3 frame rewriter. A predictor follows the
// tag header, frame headers and payloads byte by byte and queues the bytes the
// rewritten file should hold. Short hand-built and random tag files, with text
// store loads mixed in, are sent under several frame and text settings while
// both handshakes idle at random and the output side stalls for a long stretch.
// ----------------------------------------------------------------------------

import id3_pkg::*;

typedef enum logic [2:0] {
  ST_HEADER,
  ST_ID,
  ST_SIZE,
  ST_FLAGS,
  ST_PAYLOAD,
  ST_COPY
} parse_state_t;

// one byte of the rewritten file
typedef struct packed {
  logic [7:0] value;
  logic       last;
} rewrite_result_t;

class rewrite_scoreboard;
  logic [31:0]     frame_ids [6];
  logic [2:0]      frame_sel;
  logic [5:0]      text_len;
  logic [7:0]      text_mem [MAX_TEXT_DEF];
  parse_state_t    state;
  logic [31:0]     byte_pos;
  logic [28:0]     tag_end;
  logic [31:0]     field_cnt;
  logic [31:0]     size_buf;
  logic            id_match;
  rewrite_result_t step_q[$];
  rewrite_result_t expected_q[$];
  int unsigned     results_checked;
  int unsigned     mismatches;
  int unsigned     rewrites;
  int unsigned     copy_entries;
  int unsigned     loads;
  int unsigned     source_bytes;

  function new();
    frame_ids = '{ID_TIT2, ID_TPE1, ID_TALB, ID_TYER, ID_TCON, ID_COMM};
    frame_sel = 3'd0;
    text_len  = 6'd1;
    clear_parse();
  endfunction

  function void clear_parse();
    state     = ST_HEADER;
    byte_pos  = '0;
    tag_end   = '0;
    field_cnt = '0;
    size_buf  = '0;
    id_match  = 1'b0;
  endfunction

  function void set_config(logic [2:0] sel, logic [5:0] len);
    frame_sel = sel;
    text_len  = len;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function void emit(logic [7:0] v);
    step_q.push_back('{value: v, last: 1'b0});
  endfunction

  // predict the output bytes of one accepted request
  function void note_request(logic op_v, logic [7:0] b, logic [5:0] idx, logic eof_v);
    if (op_v == OP_LOAD_TEXT) begin
      loads++;
      if (idx < MAX_TEXT_DEF) text_mem[idx] = b;
      return;
    end
    source_bytes++;
    step_q = {};
    case (state)
      ST_HEADER: begin
        emit(b);
        // syncsafe tag size, 7 bits per byte
        if (byte_pos >= 6 && byte_pos <= 9)
          size_buf = ((byte_pos == 6) ? 32'd0 : (size_buf << 7)) | {25'd0, b[6:0]};
        if (byte_pos == 9) begin
          tag_end   = 29'(32'd10 + (size_buf & 32'h0FFF_FFFF));
          state     = ST_ID;
          field_cnt = '0;
        end
      end
      ST_ID: begin
        // tag end or padding switches to copy mode
        if (field_cnt == 0 && (byte_pos >= 32'(tag_end) || b == 8'h00)) begin
          state = ST_COPY;
          copy_entries++;
          emit(b);
        end else begin
          if (field_cnt == 0) id_match = 1'b1;
          if (!(frame_sel < NUM_FRAME_IDS && field_cnt < 4 &&
                frame_ids[frame_sel][8*(3-field_cnt) +: 8] == b))
            id_match = 1'b0;
          emit(b);
          field_cnt++;
          if (field_cnt >= 4) begin
            state     = ST_SIZE;
            field_cnt = '0;
            size_buf  = '0;
          end
        end
      end
      ST_SIZE: begin
        size_buf = {size_buf[23:0], b};
        field_cnt++;
        if (field_cnt >= 4) begin
          field_cnt = '0;
          if (size_buf == 0 || size_buf > 32'(tag_end)) begin
            state = ST_COPY;
            copy_entries++;
            for (int k = 0; k < 4; k++) emit(size_buf[31-8*k -: 8]);
          end else begin
            state = ST_FLAGS;
            if (id_match) begin
              rewrites++;
              emit(8'h00);
              emit(8'h00);
              emit(8'h00);
              emit(8'(text_len + 1));
            end else begin
              for (int k = 0; k < 4; k++) emit(size_buf[31-8*k -: 8]);
            end
          end
        end
      end
      ST_FLAGS: begin
        emit(b);
        field_cnt++;
        if (field_cnt >= 2) begin
          state     = ST_PAYLOAD;
          field_cnt = '0;
        end
      end
      ST_PAYLOAD: begin
        // selected frame: encoding byte and text on the first payload byte
        if (id_match) begin
          if (field_cnt == 0) begin
            emit(8'h00);
            for (int k = 0; k < text_len; k++) emit(text_mem[k]);
          end
        end else begin
          emit(b);
        end
        field_cnt++;
        if (field_cnt >= size_buf) begin
          state     = ST_ID;
          field_cnt = '0;
        end
      end
      default: emit(b);
    endcase
    byte_pos++;

    // end of file releases held size bytes
    if (eof_v) begin
      if (state == ST_SIZE)
        for (int k = 0; k < field_cnt && k < 4; k++)
          emit(8'(size_buf >> (8 * (field_cnt - 1 - k))));
      clear_parse();
    end

    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endfunction

  function void report(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  // compare one accepted output byte with the oldest prediction
  function void check_result(logic [7:0] got, logic got_last);
    rewrite_result_t want;
    results_checked++;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected out_byte=%02h run_last=%0b", got, got_last));
      return;
    end
    want = expected_q.pop_front();
    if (got !== want.value || got_last !== want.last)
      report($sformatf("result %0d: expected out_byte=%02h run_last=%0b, got %02h %0b",
                       results_checked, want.value, want.last, got, got_last));
  endfunction
endclass

module tb;

  localparam int RANDOM_ITEMS  = 170;
  localparam int QUIET_ITEMS   = 45;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int STUCK_LIMIT   = 5000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_FRAME_SELECT;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   op = OP_SOURCE;
  logic [7:0]             data_byte = '0;
  logic [5:0]             text_index = '0;
  logic                   end_of_file = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [7:0]             out_byte;
  logic                   run_last;

  rewrite_scoreboard sb;
  logic [7:0]  file_q[$];
  int unsigned sent_items;
  int unsigned files_sent;
  int unsigned gap_odds;
  logic        quiet = 1'b0;
  logic        rx_calm = 1'b0;
  logic        sending_file = 1'b0;
  logic        squeezed = 1'b0;
  int unsigned hold_left;
  int unsigned stuck_cycles;

  id3v2_frame_rewriter DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .data_byte  (data_byte),
    .text_index (text_index),
    .end_of_file(end_of_file),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_last   (run_last)
  );

  always #5 clk = ~clk;

  // output side: check, random stalls, one long hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_byte, run_last);
      if (!squeezed && sending_file && sb.results_checked > 120) begin
        squeezed = 1'b1;
        hold_left = LONG_HOLD;
      end else if (hold_left == 0 && !quiet && !rx_calm && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 17);
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: %0d cycles without progress", STUCK_LIMIT);
        $display("[id3v2_frame_rewriter] ERROR");
        $finish;
      end
    end
  end

  task automatic set_config(logic [2:0] sel, logic [5:0] len);
    cfg_write <= 1'b1;
    cfg_index <= CFG_FRAME_SELECT;
    cfg_data  <= {3'd0, sel};
    @(posedge clk);
    cfg_index <= CFG_TEXT_LENGTH;
    cfg_data  <= len;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_config(sel, len);
  endtask

  // present one request and wait for it to be taken
  task automatic offer(logic op_v, logic [7:0] b, logic [5:0] idx, logic eof_v);
    if (gap_odds != 0 && !quiet && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= op_v;
    data_byte   <= b;
    text_index  <= idx;
    end_of_file <= eof_v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(op_v, b, idx, eof_v);
    sent_items++;
  endtask

  // send file_q with text loads mixed in, end of file on the last byte
  task automatic send_file(int unsigned quiet_from);
    sending_file = 1'b1;
    foreach (file_q[i]) begin
      quiet = (sent_items >= quiet_from);
      if ($urandom_range(0, 9) == 0)
        offer(OP_LOAD_TEXT, 8'($urandom), 6'($urandom), 1'($urandom));
      offer(OP_SOURCE, file_q[i], 6'($urandom), i == file_q.size() - 1);
    end
    files_sent++;
  endtask

  // let the block empty before the next register write
  task automatic drain();
    in_valid <= 1'b0;
    sending_file = 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random tag file: header, a few frames, padding, trailing bytes
  function automatic void build_file(logic [2:0] sel);
    logic [7:0]  body[$];
    logic [31:0] pick_id;
    logic [31:0] fsize;
    logic [31:0] syncsafe_len;
    int unsigned nframes;
    int unsigned plen;
    int unsigned cut;
    file_q = {};
    nframes = $urandom_range(0, 3);
    for (int f = 0; f < nframes; f++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: pick_id = (sel < NUM_FRAME_IDS) ? sb.frame_ids[sel] : ID_TIT2;
        5, 6:          pick_id = sb.frame_ids[$urandom_range(0, 5)];
        7:             pick_id = $urandom;
        8:             pick_id = {8'h00, 24'($urandom)};
        default: begin
          // near miss: one letter off
          pick_id = sb.frame_ids[(sel < NUM_FRAME_IDS) ? sel : 3'd0];
          pick_id[8*$urandom_range(0, 3) +: 8] ^= 8'h01;
        end
      endcase
      case ($urandom_range(0, 9))
        7:       fsize = 32'd0;
        8:       fsize = $urandom;
        9:       fsize = $urandom_range(6, 12);
        default: fsize = $urandom_range(1, 5);
      endcase
      plen = (fsize <= 12) ? fsize : $urandom_range(0, 3);
      for (int k = 0; k < 4; k++) body.push_back(pick_id[31-8*k -: 8]);
      for (int k = 0; k < 4; k++) body.push_back(fsize[31-8*k -: 8]);
      body.push_back(8'($urandom));
      body.push_back(8'($urandom));
      for (int k = 0; k < plen; k++) body.push_back(8'($urandom));
    end
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) body.push_back(8'h00);
    case ($urandom_range(0, 7))
      0:       syncsafe_len = $urandom_range(0, body.size());
      1:       syncsafe_len = {4'h0, 28'($urandom)};
      2:       syncsafe_len = 32'h0FFF_FFFF;
      default: syncsafe_len = body.size() + $urandom_range(0, 4);
    endcase
    // "ID3", version, revision, flags, syncsafe size with stray top bits
    file_q.push_back(8'h49);
    file_q.push_back(8'h44);
    file_q.push_back(8'h33);
    repeat (3) file_q.push_back(8'($urandom));
    for (int k = 0; k < 4; k++)
      file_q.push_back({($urandom_range(0, 3) == 0), syncsafe_len[27-7*k -: 7]});
    foreach (body[i]) file_q.push_back(body[i]);
    repeat ($urandom_range(0, 4)) file_q.push_back(8'($urandom));
    // cut short at random, or inside the first frame size
    case ($urandom_range(0, 7))
      0:       cut = $urandom_range(1, file_q.size());
      1:       cut = 14 + $urandom_range(1, 3);
      default: cut = file_q.size();
    endcase
    while (file_q.size() > cut) void'(file_q.pop_back());
  endfunction

  initial begin
    logic [2:0]  sel;
    logic [5:0]  len;
    int unsigned base;
    int unsigned nfile;
    sb = new();
    gap_odds = 4;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: fill the text store, then a short file rewriting TIT2
    set_config(3'd0, 6'd3);
    for (int i = 0; i < MAX_TEXT_DEF; i++)
      offer(OP_LOAD_TEXT, 8'($urandom), 6'(i), 1'($urandom));
    offer(OP_LOAD_TEXT, 8'hFF, 6'd63, 1'b1);
    file_q = '{8'h49, 8'h44, 8'h33, 8'h03, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h20,
               8'h54, 8'h49, 8'h54, 8'h32, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00,
               8'hFF, 8'h00, 8'h00};
    send_file(32'hFFFF_FFFF);
    drain();

    // random files under changing settings, extremes first
    base = sent_items;
    nfile = 0;
    while (sent_items - base < RANDOM_ITEMS) begin
      case (nfile)
        0: begin sel = 3'd5; len = 6'd63; end
        1: begin sel = 3'd7; len = 6'd0;  end
        2: begin sel = 3'd1; len = 6'd1;  end
        3: begin sel = 3'd6; len = 6'd9;  end
        default: begin
          sel = $urandom_range(0, 7);
          case ($urandom_range(0, 4))
            0:       len = 6'd0;
            1:       len = 6'd63;
            default: len = $urandom_range(1, 12);
          endcase
        end
      endcase
      set_config(sel, len);
      case ($urandom_range(0, 2))
        0:       gap_odds = 0;
        1:       gap_odds = 3;
        default: gap_odds = 10;
      endcase
      rx_calm = ($urandom_range(0, 2) == 0);
      build_file(sel);
      send_file(base + RANDOM_ITEMS - QUIET_ITEMS);
      drain();
      nfile++;
    end

    repeat (20) @(posedge clk);
    $display("run: %0d files, %0d source bytes, %0d text loads, %0d output bytes checked",
             files_sent, sb.source_bytes, sb.loads, sb.results_checked);
    $display("run: %0d frames rewritten, %0d copy mode starts, %0d mismatches",
             sb.rewrites, sb.copy_entries, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[id3v2_frame_rewriter] OK");
    end else begin
      $display("[id3v2_frame_rewriter] ERROR");
    end
    $finish;
  end

endmodule
